// ===== design/ubd_pkg.sv =====
// Shared types, constants and decode functions for the Unicode mark detector and decoder.
// Used by the front end, the back end and the top level; depends on nothing else.
`default_nettype none

package ubd_pkg;

  // Encoding in use for the current text.
  typedef enum logic [2:0] {
    ENC_ASCII   = 3'd0,
    ENC_UTF8    = 3'd1,
    ENC_UTF16BE = 3'd2,
    ENC_UTF16LE = 3'd3,
    ENC_UTF32BE = 3'd4,
    ENC_UTF32LE = 3'd5
  } enc_t;

  // Mode register codes that ask for mark detection.
  localparam logic [3:0] MODE_SIGNATURE = 4'd6;
  localparam logic [3:0] MODE_UTF16     = 4'd7;
  localparam logic [3:0] MODE_UTF32     = 4'd8;
  localparam logic [3:0] MODE_RESET     = MODE_SIGNATURE;

  // One chunk of assembled bytes handed from the front end to the back end.
  // Byte 0 sits in word[7:0]; bytes at or above fill are zero.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  fill;
    enc_t        enc;
    logic        last;
  } job_t;

  // One result transaction.
  typedef struct packed {
    logic [20:0] code_point;
    logic        has_char;
    logic        end_of_text;
    enc_t        detected_encoding;
  } result_t;

  // Number of bytes the unit at the front of the word takes.
  function automatic logic [2:0] unit_need(enc_t enc, logic [31:0] word, logic [2:0] fill);
    logic [7:0] b0;
    logic [7:0] hi;
    logic [2:0] need;
    b0 = word[7:0];
    hi = (enc == ENC_UTF16BE) ? word[7:0] : word[15:8];
    case (enc)
      ENC_UTF8: begin
        if (b0 < 8'h80)      need = 3'd1;
        else if (b0 < 8'hE0) need = 3'd2;
        else if (b0 < 8'hF0) need = 3'd3;
        else                 need = 3'd4;
      end
      ENC_UTF16BE, ENC_UTF16LE: begin
        if (fill < 3'd2)                    need = 3'd2;
        else if (hi inside {[8'hD8:8'hDB]}) need = 3'd4;
        else                                need = 3'd2;
      end
      ENC_UTF32BE, ENC_UTF32LE: need = 3'd4;
      default: need = 3'd1;
    endcase
    return need;
  endfunction

  // Code point of the unit at the front of the word; zero means no character.
  function automatic logic [20:0] unit_value(enc_t enc, logic [31:0] word);
    logic [7:0]  b0, b1, b2, b3;
    logic [7:0]  hi, lo, hi2, lo2;
    logic [31:0] v32;
    logic [20:0] val;
    b0 = word[7:0];
    b1 = word[15:8];
    b2 = word[23:16];
    b3 = word[31:24];
    if (enc == ENC_UTF16BE) begin
      hi = b0; lo = b1; hi2 = b2; lo2 = b3;
    end else begin
      hi = b1; lo = b0; hi2 = b3; lo2 = b2;
    end
    v32 = (enc == ENC_UTF32BE) ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    case (enc)
      ENC_UTF8: begin
        if (b0 < 8'h80)      val = {13'd0, b0};
        else if (b0 < 8'hE0) val = {10'd0, b0[4:0], b1[5:0]};
        else if (b0 < 8'hF0) val = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        else if (b0 < 8'hF8) val = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        else                 val = 21'd0;
      end
      ENC_UTF16BE, ENC_UTF16LE: begin
        if (!(hi inside {[8'hD8:8'hDF]})) begin
          val = {5'd0, hi, lo};
        end else if ((hi inside {[8'hD8:8'hDB]}) && (hi2 inside {[8'hDC:8'hDF]})) begin
          // Surrogate pair: ten bits from each unit plus the supplementary offset.
          val = {1'b0, hi[1:0], lo, hi2[1:0], lo2} + 21'h10000;
        end else begin
          val = 21'd0;
        end
      end
      ENC_UTF32BE, ENC_UTF32LE: begin
        if (v32[31:24] == 8'h00 && v32[23:16] <= 8'h10) val = v32[20:0];
        else                                            val = 21'd0;
      end
      default: val = {13'd0, b0};
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/ubd_fifo.sv =====
// Small first-word-fall-through queue of flip-flops, used for jobs and for results.
// Self-contained; DEPTH must be a power of two of at least two.
`default_nettype none

module ubd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] FULL_CNT = DEPTH[AW:0];

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  // Status and head of the queue.
  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ubd_front.sv =====
// Front end: assembles incoming bytes, detects the byte-order mark and cuts jobs.
// Depends on ubd_pkg for the job type and the unit length function.
`default_nettype none

module ubd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  input  wire logic [3:0]    text_encoding,
  output logic               job_push,
  output ubd_pkg::job_t      job
);

  logic [31:0]       word;
  logic [1:0]        fill;
  ubd_pkg::enc_t     active_enc;
  logic              at_start;

  logic [31:0]       word_next;
  logic [1:0]        fill_next;
  ubd_pkg::enc_t     active_enc_next;
  logic              at_start_next;

  ubd_pkg::enc_t     enc_sel;
  logic              start_sel;
  logic [31:0]       app_word;
  logic [2:0]        app_fill;
  ubd_pkg::enc_t     det_enc;
  logic [2:0]        skip;
  logic [2:0]        drop;
  logic              detect;
  logic              hold_start;
  ubd_pkg::enc_t     dec_enc;
  logic [31:0]       dec_word;
  logic [2:0]        dec_fill;
  logic [2:0]        need;
  logic              complete;

  // Encoding choice, byte append and mark detection.
  always_comb begin
    enc_sel   = active_enc;
    start_sel = at_start;
    if (at_start && fill == 2'd0) begin
      if (text_encoding < ubd_pkg::MODE_SIGNATURE) begin
        enc_sel   = ubd_pkg::enc_t'(text_encoding[2:0]);
        start_sel = 1'b0;
      end else if (text_encoding > ubd_pkg::MODE_UTF32) begin
        enc_sel   = ubd_pkg::ENC_ASCII;
        start_sel = 1'b0;
      end
    end

    app_word = word | ({24'd0, data_byte} << {fill, 3'b000});
    app_fill = {1'b0, fill} + 3'd1;

    det_enc = ubd_pkg::ENC_ASCII;
    skip    = 3'd0;
    if (app_word[7:0] == 8'hEF && app_word[15:8] == 8'hBB && app_word[23:16] == 8'hBF) begin
      det_enc = ubd_pkg::ENC_UTF8;
      skip    = 3'd3;
    end else if (app_word[7:0] == 8'hFE && app_word[15:8] == 8'hFF) begin
      det_enc = ubd_pkg::ENC_UTF16BE;
      skip    = 3'd2;
    end else if (app_word[7:0] == 8'hFF && app_word[15:8] == 8'hFE) begin
      if (app_word[31:16] == 16'h0000 && text_encoding != ubd_pkg::MODE_UTF16) begin
        det_enc = ubd_pkg::ENC_UTF32LE;
        skip    = 3'd4;
      end else begin
        det_enc = ubd_pkg::ENC_UTF16LE;
        skip    = 3'd2;
      end
    end else if (app_word[15:0] == 16'h0000 && app_word[23:16] == 8'hFE &&
                 app_word[31:24] == 8'hFF) begin
      det_enc = ubd_pkg::ENC_UTF32BE;
      skip    = 3'd4;
    end

    detect     = start_sel && (app_fill == 3'd4 || last_byte);
    hold_start = start_sel && !detect;
    drop       = (skip > app_fill) ? app_fill : skip;

    if (detect) begin
      dec_enc  = det_enc;
      dec_word = app_word >> {drop, 3'b000};
      dec_fill = app_fill - drop;
    end else begin
      dec_enc  = enc_sel;
      dec_word = app_word;
      dec_fill = app_fill;
    end

    need     = ubd_pkg::unit_need(dec_enc, dec_word, dec_fill);
    complete = (dec_fill != 3'd0) && (dec_fill >= need);
  end

  // Job hand-off: a complete unit, or everything held at the end of a text.
  always_comb begin
    job_push = in_fire && !hold_start && (last_byte || complete);
    job      = '{word: dec_word, fill: dec_fill, enc: dec_enc, last: last_byte};
  end

  // Next state of the assembly buffer.
  always_comb begin
    word_next       = word;
    fill_next       = fill;
    active_enc_next = active_enc;
    at_start_next   = at_start;
    if (in_fire) begin
      active_enc_next = dec_enc;
      if (last_byte) begin
        word_next     = 32'd0;
        fill_next     = 2'd0;
        at_start_next = 1'b1;
      end else if (hold_start) begin
        word_next     = app_word;
        fill_next     = app_fill[1:0];
        at_start_next = 1'b1;
      end else if (complete) begin
        word_next     = 32'd0;
        fill_next     = 2'd0;
        at_start_next = 1'b0;
      end else begin
        word_next     = dec_word;
        fill_next     = dec_fill[1:0];
        at_start_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word       <= 32'd0;
      fill       <= 2'd0;
      active_enc <= ubd_pkg::ENC_ASCII;
      at_start   <= 1'b1;
    end else begin
      word       <= word_next;
      fill       <= fill_next;
      active_enc <= active_enc_next;
      at_start   <= at_start_next;
    end
  end

`ifndef SYNTHESIS
  // Bytes beyond the fill level must stay zero, since detection reads them.
  assert property (@(posedge clk) disable iff (rst)
    (word >> {fill, 3'b000}) == 32'd0)
    else $error("front: stale byte above fill level");

  // The end of a text always rearms detection with an empty buffer.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> at_start && fill == 2'd0)
    else $error("front: buffer not cleared after end of text");
`endif

endmodule

`default_nettype wire

// ===== design/ubd_back.sv =====
// Back end: decodes one unit per cycle from each job, unless the result queue is full, into result transactions.
// Depends on ubd_pkg for the job and result types and the decode functions.
`default_nettype none

module ubd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_empty,
  input  wire ubd_pkg::job_t     job,
  output logic                   job_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output ubd_pkg::result_t       res
);

  logic              busy;
  ubd_pkg::job_t     cur;
  logic              held_v;
  logic [20:0]       held_cp;
  logic              fin;

  logic              busy_next;
  ubd_pkg::job_t     cur_next;
  logic              held_v_next;
  logic [20:0]       held_cp_next;
  logic              fin_next;

  logic [2:0]        need;
  logic [20:0]       value;
  logic [2:0]        take;
  logic [2:0]        rest_fill;
  logic              cur_nz;
  logic              go;
  logic              final_step;
  logic              done;

  // One decode step on the front unit of the current job.
  always_comb begin
    need       = ubd_pkg::unit_need(cur.enc, cur.word, cur.fill);
    value      = ubd_pkg::unit_value(cur.enc, cur.word);
    take       = (need > cur.fill) ? cur.fill : need;
    rest_fill  = cur.fill - take;
    cur_nz     = (cur.fill != 3'd0) && (value != 21'd0);
    go         = busy && !res_full;
    final_step = (rest_fill == 3'd0);
  end

  // Result writes. At the end of a text the last character is held back so that
  // it can carry the end-of-text flag.
  always_comb begin
    res_push     = 1'b0;
    res          = '{code_point: value, has_char: 1'b1, end_of_text: 1'b0,
                     detected_encoding: cur.enc};
    cur_next     = cur;
    held_v_next  = held_v;
    held_cp_next = held_cp;
    fin_next     = fin;
    done         = 1'b0;

    if (go) begin
      if (fin) begin
        res_push    = 1'b1;
        res         = '{code_point: held_cp, has_char: 1'b1, end_of_text: 1'b1,
                        detected_encoding: cur.enc};
        held_v_next = 1'b0;
        fin_next    = 1'b0;
        done        = 1'b1;
      end else begin
        cur_next.word = cur.word >> {take, 3'b000};
        cur_next.fill = rest_fill;
        if (!cur.last) begin
          res_push = cur_nz;
          done     = final_step;
        end else if (!final_step) begin
          if (cur_nz) begin
            res_push     = held_v;
            res          = '{code_point: held_cp, has_char: 1'b1, end_of_text: 1'b0,
                             detected_encoding: cur.enc};
            held_cp_next = value;
            held_v_next  = 1'b1;
          end
        end else if (!held_v) begin
          // Last unit of the text and nothing held: it carries the flag itself,
          // or a bare end marker goes out.
          res_push = 1'b1;
          res      = '{code_point: cur_nz ? value : 21'd0, has_char: cur_nz,
                       end_of_text: 1'b1, detected_encoding: cur.enc};
          done     = 1'b1;
        end else if (!cur_nz) begin
          res_push    = 1'b1;
          res         = '{code_point: held_cp, has_char: 1'b1, end_of_text: 1'b1,
                          detected_encoding: cur.enc};
          held_v_next = 1'b0;
          done        = 1'b1;
        end else begin
          // Two characters remain: send the held one now and the last one in the closing step.
          res_push     = 1'b1;
          res          = '{code_point: held_cp, has_char: 1'b1, end_of_text: 1'b0,
                           detected_encoding: cur.enc};
          held_cp_next = value;
          fin_next     = 1'b1;
        end
      end
    end
  end

  // Job loading, overlapped with the final step of the previous job.
  always_comb begin
    job_pop   = !job_empty && (!busy || done);
    busy_next = busy;
    if (job_pop) begin
      busy_next = 1'b1;
    end else if (done) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      held_v <= 1'b0;
      fin    <= 1'b0;
    end else begin
      busy   <= busy_next;
      held_v <= held_v_next;
      fin    <= fin_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= job_pop ? job : cur_next;
    held_cp <= held_cp_next;
  end

`ifndef SYNTHESIS
  // A held character only exists while the end of a text is being decoded.
  assert property (@(posedge clk) disable iff (rst)
    held_v |-> busy && cur.last)
    else $error("back: held character outside an end-of-text job");

  // The closing cycle always has a held character to send.
  assert property (@(posedge clk) disable iff (rst)
    fin |-> held_v && cur.fill == 3'd0)
    else $error("back: closing cycle without a held character");
`endif

endmodule

`default_nettype wire

// ===== design/unicode_bom_detect_and_decode_top.sv =====
// Unicode byte-order-mark detector and decoder: ASCII, UTF-8, UTF-16 and UTF-32.
// Takes one byte per cycle while the job queue is not full; a byte that completes a unit
// sends its result through the job queue, the back end's job register and the result queue.
// The back end decodes one unit per cycle while the result queue has room; the job queue absorbs
// the units of one byte (after mark detection or at the end of a text) and any end-of-text step.
// Synchronous reset empties both queues, clears the buffer and sets the mode to signature.
`default_nettype none

module unicode_bom_detect_and_decode_top #(
  parameter int JOB_DEPTH = 4,
  parameter int RES_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Byte input.
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // Results.
  output logic             empty,
  input  wire logic        pop,
  output logic [20:0]      code_point,
  output logic             has_char,
  output logic             end_of_text,
  output logic [2:0]       detected_encoding,
  // Mode register write.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  localparam int JOB_W = $bits(ubd_pkg::job_t);
  localparam int RES_W = $bits(ubd_pkg::result_t);

  logic [3:0]          text_encoding;
  logic                in_fire;
  logic                job_push;
  ubd_pkg::job_t       job_w;
  logic [JOB_W-1:0]    job_rdata;
  logic                job_pop;
  logic                job_full;
  logic                job_empty;
  logic                res_push;
  ubd_pkg::result_t    res_w;
  logic [RES_W-1:0]    res_rdata;
  ubd_pkg::result_t    res_head;
  logic                res_full;

  // Mode register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_encoding <= ubd_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_encoding <= cfg_data;
    end
  end

  // Input transaction.
  assign full    = job_full;
  assign in_fire = push && !full;

  ubd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .text_encoding (text_encoding),
    .job_push      (job_push),
    .job           (job_w)
  );

  ubd_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_w),
    .pop   (job_pop),
    .rdata (job_rdata),
    .full  (job_full),
    .empty (job_empty)
  );

  ubd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (ubd_pkg::job_t'(job_rdata)),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_w)
  );

  ubd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_w),
    .pop   (pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (empty)
  );

  // Result ports from the head of the result queue.
  assign res_head          = ubd_pkg::result_t'(res_rdata);
  assign code_point        = res_head.code_point;
  assign has_char          = res_head.has_char;
  assign end_of_text       = res_head.end_of_text;
  assign detected_encoding = res_head.detected_encoding;

endmodule

`default_nettype wire

// ===== verif/tb_unicode_bom_detect_and_decode_top.sv =====
// Self-checking testbench for the Unicode mark detector and decoder top level.
// Runs a transaction-level predictor of the decoder next to the RTL; depends on ubd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_unicode_bom_detect_and_decode_top;

  // Mode codes outside the defined set decode as plain ASCII.
  localparam logic [3:0] MODE_UNUSED_MIN = 4'd9;
  localparam logic [3:0] MODE_UNUSED_MAX = 4'd15;
  localparam int IDLE_PCT      = 38;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_BYTES  = 160;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        empty;
  logic        pop;
  logic [20:0] code_point;
  logic        has_char;
  logic        end_of_text;
  logic [2:0]  detected_encoding;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  // Predictor state: mode register, assembly buffer and text status.
  logic [3:0]       mode_reg;
  logic [7:0]       asm_buf [4];
  int unsigned      asm_fill;
  ubd_pkg::enc_t    text_enc;
  bit               text_open;

  ubd_pkg::result_t pending_codes [$];
  logic [7:0]       text_bytes [$];
  bit               steady;
  int               fail_count;
  int               bytes_sent;
  int               texts_sent;
  int               codes_checked;
  int               mode_writes;

  unicode_bom_detect_and_decode_top i_dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .data_byte         (data_byte),
    .last_byte         (last_byte),
    .empty             (empty),
    .pop               (pop),
    .code_point        (code_point),
    .has_char          (has_char),
    .end_of_text       (end_of_text),
    .detected_encoding (detected_encoding),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the design hangs.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Removes n bytes from the front of the buffer and zero-fills the tail.
  function automatic void shift_out(int unsigned n);
    int unsigned k;
    k = (n > asm_fill) ? asm_fill : n;
    for (int i = 0; i < 4; i++) begin
      asm_buf[i] = (i + k < 4) ? asm_buf[i + k] : 8'h00;
    end
    asm_fill -= k;
  endfunction

  // Bytes taken by the unit at the front of the buffer.
  function automatic int unsigned unit_len();
    logic [7:0] hi;
    hi = (text_enc == ubd_pkg::ENC_UTF16BE) ? asm_buf[0] : asm_buf[1];
    case (text_enc)
      ubd_pkg::ENC_UTF8: begin
        if (asm_buf[0] < 8'h80) return 1;
        if (asm_buf[0] < 8'hE0) return 2;
        if (asm_buf[0] < 8'hF0) return 3;
        return 4;
      end
      ubd_pkg::ENC_UTF16BE, ubd_pkg::ENC_UTF16LE: begin
        if (asm_fill < 2) return 2;
        return (hi >= 8'hD8 && hi <= 8'hDB) ? 4 : 2;
      end
      ubd_pkg::ENC_UTF32BE, ubd_pkg::ENC_UTF32LE: return 4;
      default: return 1;
    endcase
  endfunction

  // Character value of the unit at the front of the buffer; zero means none.
  function automatic int unsigned unit_code();
    int unsigned b0, b1, b2, b3, hi, lo, hi2, lo2, v;
    b0 = asm_buf[0];
    b1 = asm_buf[1];
    b2 = asm_buf[2];
    b3 = asm_buf[3];
    case (text_enc)
      ubd_pkg::ENC_UTF8: begin
        if (b0 < 'h80) return b0;
        if (b0 < 'hE0) return ((b0 & 'h1F) << 6) | (b1 & 'h3F);
        if (b0 < 'hF0) return ((b0 & 'h0F) << 12) | ((b1 & 'h3F) << 6) | (b2 & 'h3F);
        if (b0 < 'hF8) begin
          return ((b0 & 'h07) << 18) | ((b1 & 'h3F) << 12) | ((b2 & 'h3F) << 6) | (b3 & 'h3F);
        end
        return 0;
      end
      ubd_pkg::ENC_UTF16BE, ubd_pkg::ENC_UTF16LE: begin
        if (text_enc == ubd_pkg::ENC_UTF16BE) begin
          hi = b0; lo = b1; hi2 = b2; lo2 = b3;
        end else begin
          hi = b1; lo = b0; hi2 = b3; lo2 = b2;
        end
        if (hi <= 'hD7 || hi >= 'hE0) return (hi << 8) | lo;
        if (hi <= 'hDB && hi2 >= 'hDC && hi2 <= 'hDF) begin
          return ((((hi << 8) | lo) - 'hD800) << 10) + (((hi2 << 8) | lo2) - 'hDC00) + 'h10000;
        end
        return 0;
      end
      ubd_pkg::ENC_UTF32BE, ubd_pkg::ENC_UTF32LE: begin
        if (text_enc == ubd_pkg::ENC_UTF32BE) v = (b0 << 24) | (b1 << 16) | (b2 << 8) | b3;
        else v = (b3 << 24) | (b2 << 16) | (b1 << 8) | b0;
        return (v < 'h110000) ? v : 0;
      end
      default: return b0;
    endcase
  endfunction

  // Looks for a byte-order mark in the held bytes and drops it.
  function automatic void detect_bom();
    ubd_pkg::enc_t e;
    int unsigned   drop;
    e = ubd_pkg::ENC_ASCII;
    drop = 0;
    if (asm_buf[0] == 8'hEF && asm_buf[1] == 8'hBB && asm_buf[2] == 8'hBF) begin
      e = ubd_pkg::ENC_UTF8; drop = 3;
    end else if (asm_buf[0] == 8'hFE && asm_buf[1] == 8'hFF) begin
      e = ubd_pkg::ENC_UTF16BE; drop = 2;
    end else if (asm_buf[0] == 8'hFF && asm_buf[1] == 8'hFE) begin
      if (asm_buf[2] == 8'h00 && asm_buf[3] == 8'h00 &&
          mode_reg != ubd_pkg::MODE_UTF16) begin
        e = ubd_pkg::ENC_UTF32LE; drop = 4;
      end else begin
        e = ubd_pkg::ENC_UTF16LE; drop = 2;
      end
    end else if (asm_buf[0] == 8'h00 && asm_buf[1] == 8'h00 &&
                 asm_buf[2] == 8'hFE && asm_buf[3] == 8'hFF) begin
      e = ubd_pkg::ENC_UTF32BE; drop = 4;
    end
    text_enc = e;
    shift_out(drop);
    text_open = 1'b0;
  endfunction

  // Works out the results caused by one accepted byte and queues them.
  function automatic void decode_byte(logic [7:0] b, logic is_last);
    ubd_pkg::result_t res [4];
    int               count;
    int unsigned      need, v;
    count = 0;
    if (text_open && asm_fill == 0) begin
      if (mode_reg < ubd_pkg::MODE_SIGNATURE) begin
        text_enc = ubd_pkg::enc_t'(mode_reg[2:0]);
        text_open = 1'b0;
      end else if (mode_reg > ubd_pkg::MODE_UTF32) begin
        text_enc = ubd_pkg::ENC_ASCII;
        text_open = 1'b0;
      end
    end
    if (asm_fill < 4) begin
      asm_buf[asm_fill] = b;
      asm_fill++;
    end
    if (text_open) begin
      if (asm_fill < 4 && !is_last) return;
      detect_bom();
    end
    while (asm_fill > 0 && count < 4) begin
      need = unit_len();
      if (need > asm_fill && !is_last) break;
      v = unit_code();
      shift_out(need);
      if (v != 0) begin
        res[count] = '{code_point: v[20:0], has_char: 1'b1, end_of_text: 1'b0,
                       detected_encoding: text_enc};
        count++;
      end
    end
    if (is_last) begin
      // A text that ends without a character still gets an end marker.
      if (count == 0) begin
        res[0] = '{code_point: 21'd0, has_char: 1'b0, end_of_text: 1'b0,
                   detected_encoding: text_enc};
        count = 1;
      end
      res[count - 1].end_of_text = 1'b1;
      for (int i = 0; i < 4; i++) asm_buf[i] = 8'h00;
      asm_fill = 0;
      text_open = 1'b1;
    end
    for (int i = 0; i < count; i++) pending_codes.insert(pending_codes.size(), res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Sends one byte transaction and predicts what it causes.
  task automatic send_byte(logic [7:0] b, logic is_last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    do @(posedge clk); while (full);
    decode_byte(b, is_last);
    bytes_sent++;
    if (is_last) texts_sent++;
  endtask

  // Sends the bytes collected in text_bytes as one text.
  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
    text_bytes.delete();
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the mode register once the decoder is quiet.
  task automatic write_mode(logic [3:0] m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_reg = m;
    mode_writes++;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: random pops, and every accepted result checked in order.
  initial begin
    ubd_pkg::result_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_codes.size() == 0) begin
          $error("code_point: unexpected result 0x%0h with nothing pending", code_point);
          fail_count++;
        end else begin
          want = pending_codes.pop_front();
          check_field("code_point", want.code_point, code_point);
          check_field("has_char", want.has_char, has_char);
          check_field("end_of_text", want.end_of_text, end_of_text);
          check_field("detected_encoding", want.detected_encoding, detected_encoding);
          codes_checked++;
        end
      end
      pop <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Appends one raw byte to the text being built.
  task automatic append_byte(logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  task automatic append_unit16(ubd_pkg::enc_t e, logic [15:0] u);
    if (e == ubd_pkg::ENC_UTF16BE) begin
      append_byte(u[15:8]);
      append_byte(u[7:0]);
    end else begin
      append_byte(u[7:0]);
      append_byte(u[15:8]);
    end
  endtask

  // Appends one character in the given encoding.
  task automatic append_code(ubd_pkg::enc_t e, logic [31:0] cp);
    logic [31:0] u;
    u = cp - 32'h10000;
    case (e)
      ubd_pkg::ENC_UTF8: begin
        if (cp < 32'h80) begin
          append_byte(cp[7:0]);
        end else if (cp < 32'h800) begin
          append_byte({3'b110, cp[10:6]});
          append_byte({2'b10, cp[5:0]});
        end else if (cp < 32'h10000) begin
          append_byte({4'b1110, cp[15:12]});
          append_byte({2'b10, cp[11:6]});
          append_byte({2'b10, cp[5:0]});
        end else begin
          append_byte({5'b11110, cp[20:18]});
          append_byte({2'b10, cp[17:12]});
          append_byte({2'b10, cp[11:6]});
          append_byte({2'b10, cp[5:0]});
        end
      end
      ubd_pkg::ENC_UTF16BE, ubd_pkg::ENC_UTF16LE: begin
        if (cp < 32'h10000) begin
          append_unit16(e, cp[15:0]);
        end else begin
          append_unit16(e, {6'b110110, u[19:10]});
          append_unit16(e, {6'b110111, u[9:0]});
        end
      end
      ubd_pkg::ENC_UTF32BE: begin
        append_byte(cp[31:24]);
        append_byte(cp[23:16]);
        append_byte(cp[15:8]);
        append_byte(cp[7:0]);
      end
      ubd_pkg::ENC_UTF32LE: begin
        append_byte(cp[7:0]);
        append_byte(cp[15:8]);
        append_byte(cp[23:16]);
        append_byte(cp[31:24]);
      end
      default: append_byte(cp[7:0]);
    endcase
  endtask

  // Appends the byte-order mark of an encoding; ASCII has none.
  task automatic append_mark(ubd_pkg::enc_t e);
    case (e)
      ubd_pkg::ENC_UTF8:    append_code(ubd_pkg::ENC_UTF8, 32'hFEFF);
      ubd_pkg::ENC_UTF16BE: append_unit16(ubd_pkg::ENC_UTF16BE, 16'hFEFF);
      ubd_pkg::ENC_UTF16LE: append_unit16(ubd_pkg::ENC_UTF16LE, 16'hFEFF);
      ubd_pkg::ENC_UTF32BE: append_code(ubd_pkg::ENC_UTF32BE, 32'hFEFF);
      ubd_pkg::ENC_UTF32LE: append_code(ubd_pkg::ENC_UTF32LE, 32'hFEFF);
      default: ;
    endcase
  endtask

  // Random character, now and then a surrogate or an out-of-range value.
  function automatic logic [31:0] pick_code(ubd_pkg::enc_t e);
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(32'h7F, 32'h1);
      4, 5:       return $urandom_range(32'h7FF, 32'h80);
      6, 7:       return $urandom_range(32'hFFFF, 32'h800);
      8:          return $urandom_range(32'h10FFFF, 32'h10000);
      default: begin
        if (e == ubd_pkg::ENC_UTF32BE || e == ubd_pkg::ENC_UTF32LE) return $urandom();
        if (e == ubd_pkg::ENC_UTF16BE || e == ubd_pkg::ENC_UTF16LE) begin
          return $urandom_range(32'hDFFF, 32'hD800);
        end
        return $urandom_range(32'h1FFFFF, 32'h0);
      end
    endcase
  endfunction

  // Builds one random text: mostly well-formed, sometimes cut short or pure noise.
  task automatic build_text(logic [3:0] m);
    ubd_pkg::enc_t e;
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(8, 1)) append_byte(8'($urandom()));
    end else begin
      if (m >= ubd_pkg::MODE_SIGNATURE && m <= ubd_pkg::MODE_UTF32) begin
        e = ubd_pkg::enc_t'($urandom_range(5, 0));
        if ($urandom_range(9) != 0) append_mark(e);
      end else if (m < ubd_pkg::MODE_SIGNATURE) begin
        e = ubd_pkg::enc_t'(m[2:0]);
      end else begin
        e = ubd_pkg::ENC_ASCII;
      end
      repeat ($urandom_range(6, 0)) append_code(e, pick_code(e));
      if ($urandom_range(7) == 0 && text_bytes.size() > 1) void'(text_bytes.pop_back());
      if (text_bytes.size() == 0) append_byte(8'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Lowest and highest bytes, and a text with no character at all.
  task automatic test_ascii_and_empty();
    write_mode({1'b0, ubd_pkg::ENC_ASCII});
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // Two-byte form, an invalid lead that swallows the next three bytes, and a lone byte ending the text.
  task automatic test_utf8_forms();
    write_mode({1'b0, ubd_pkg::ENC_UTF8});
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  // Mark detection at the last byte, and a mark that fills the whole text.
  task automatic test_short_marks();
    write_mode(ubd_pkg::MODE_SIGNATURE);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBB, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // A lone low surrogate, then a proper pair in little-endian order.
  task automatic test_utf16_surrogates();
    write_mode({1'b0, ubd_pkg::ENC_UTF16LE});
    send_byte(8'h00, 1'b0);
    send_byte(8'hDC, 1'b0);
    send_byte(8'h3D, 1'b0);
    send_byte(8'hD8, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hDE, 1'b1);
  endtask

  // FF FE 00 00 reads as UTF-16 LE in UTF-16 mode and as UTF-32 LE otherwise.
  task automatic test_wide_marks();
    write_mode(ubd_pkg::MODE_UTF16);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
    write_mode(ubd_pkg::MODE_UTF32);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Unused mode codes skip mark detection.
  task automatic test_unused_mode();
    write_mode(MODE_UNUSED_MAX);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // A mode write in the middle of a text only applies to the next text.
  task automatic test_mode_latch();
    write_mode({1'b0, ubd_pkg::ENC_UTF8});
    send_byte(8'hC3, 1'b0);
    write_mode({1'b0, ubd_pkg::ENC_ASCII});
    send_byte(8'hA9, 1'b1);
  endtask

  // Random texts under random modes, with a stretch of back-to-back traffic.
  task automatic test_random_texts();
    int          base;
    logic [3:0]  m;
    int unsigned pick;
    base = bytes_sent;
    while (bytes_sent < base + RANDOM_BYTES) begin
      pick = $urandom_range(19);
      m = (pick < 16) ? 4'(pick % 9) : 4'($urandom_range(MODE_UNUSED_MAX, MODE_UNUSED_MIN));
      write_mode(m);
      repeat ($urandom_range(3, 1)) begin
        steady = (bytes_sent >= base + 60) && (bytes_sent < base + 120);
        build_text(m);
        send_text();
      end
    end
    steady = 1'b0;
  endtask

  // Main sequence.
  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= ubd_pkg::MODE_RESET;
    steady = 1'b0;
    fail_count = 0;
    bytes_sent = 0;
    texts_sent = 0;
    codes_checked = 0;
    mode_writes = 0;
    mode_reg = ubd_pkg::MODE_RESET;
    for (int i = 0; i < 4; i++) asm_buf[i] = 8'h00;
    asm_fill = 0;
    text_enc = ubd_pkg::ENC_ASCII;
    text_open = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ascii_and_empty();
    test_utf8_forms();
    test_short_marks();
    test_utf16_surrogates();
    test_wide_marks();
    test_unused_mode();
    test_mode_latch();
    test_random_texts();

    wait_idle();
    $display("Decoded %0d bytes in %0d texts over %0d mode writes; %0d results checked.",
             bytes_sent, texts_sent, mode_writes, codes_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ubd_pkg.sv
design/ubd_fifo.sv
design/ubd_front.sv
design/ubd_back.sv
design/unicode_bom_detect_and_decode_top.sv
verif/tb_unicode_bom_detect_and_decode_top.sv
